@@ src/run_queue_deque_with_key_delete_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the run queue deque
// Concurrent checks that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef RUN_QUEUE_DEQUE_WITH_KEY_DELETE_MACROS_SVH
`define RUN_QUEUE_DEQUE_WITH_KEY_DELETE_MACROS_SVH

`ifndef SYNTHESIS
`define RQD_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define RQD_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define RQD_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define RQD_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

@@ src/rqd_pkg.sv @@
// ----------------------------------------------------------------------------
// rqd_pkg
// Types, constants and helpers shared by the run queue deque modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rqd_pkg;

	localparam int DEPTH = 16;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int KEY_W = 64;
	localparam int VAL_W = 64;
	localparam int POS_W = 4;
	localparam int OCC_W = 5;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [2:0] {
		OP_PUSH_TAIL = 3'd0,
		OP_PUSH_HEAD = 3'd1,
		OP_POP_HEAD  = 3'd2,
		OP_DELETE    = 3'd3,
		OP_FIND      = 3'd4,
		OP_CLEAR     = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_POP_FIN,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR
	} state_t;

	typedef struct packed {
		logic    load;
		logic    push_tail;
		logic    push_head;
		logic    pop_rd;
		logic    pop_fin;
		logic    scan_init;
		logic    scan_rd;
		logic    scan_adv;
		logic    shift_rd;
		logic    shift_wr;
		logic    del_fin;
		logic    clear;
		logic    finish;
		logic    fin_pos;
		status_t status;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic full;
		logic empty;
		logic scan_end;
		logic match;
		logic shift_end;
	} stat_t;

	function automatic ptr_t slot_next(input ptr_t p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
	endfunction

	function automatic ptr_t slot_prev(input ptr_t p);
		return (p == '0) ? PTR_W'(DEPTH - 1) : ptr_t'(p - 1'b1);
	endfunction

endpackage

`default_nettype wire

@@ src/rqd_ctrl.sv @@
// ----------------------------------------------------------------------------
// rqd_ctrl
// Operation sequencer: decodes, walks the key scan and the compaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rqd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire rqd_pkg::stat_t st,
	output rqd_pkg::cmd_t      cmd
);

	rqd_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rqd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.status = rqd_pkg::ST_OK;
		busy       = (state_q != rqd_pkg::S_IDLE);
		case (state_q)
			rqd_pkg::S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = rqd_pkg::S_DECODE;
				end
			end
			rqd_pkg::S_DECODE: begin
				state_d = rqd_pkg::S_IDLE;
				case (st.op)
					rqd_pkg::OP_PUSH_TAIL: begin
						cmd.finish = 1'b1;
						if (st.full) begin
							cmd.status = rqd_pkg::ST_FULL;
						end else begin
							cmd.push_tail = 1'b1;
						end
					end
					rqd_pkg::OP_PUSH_HEAD: begin
						cmd.finish = 1'b1;
						if (st.full) begin
							cmd.status = rqd_pkg::ST_FULL;
						end else begin
							cmd.push_head = 1'b1;
						end
					end
					rqd_pkg::OP_POP_HEAD: begin
						if (st.empty) begin
							cmd.finish = 1'b1;
							cmd.status = rqd_pkg::ST_EMPTY;
						end else begin
							cmd.pop_rd = 1'b1;
							state_d    = rqd_pkg::S_POP_FIN;
						end
					end
					rqd_pkg::OP_DELETE, rqd_pkg::OP_FIND: begin
						cmd.scan_init = 1'b1;
						state_d       = rqd_pkg::S_SCAN_RD;
					end
					rqd_pkg::OP_CLEAR: begin
						cmd.clear  = 1'b1;
						cmd.finish = 1'b1;
					end
					default: begin
						cmd.finish = 1'b1;
					end
				endcase
			end
			rqd_pkg::S_POP_FIN: begin
				cmd.pop_fin = 1'b1;
				cmd.finish  = 1'b1;
				state_d     = rqd_pkg::S_IDLE;
			end
			rqd_pkg::S_SCAN_RD: begin
				if (st.scan_end) begin
					cmd.finish = 1'b1;
					cmd.status = rqd_pkg::ST_NOT_FOUND;
					state_d    = rqd_pkg::S_IDLE;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = rqd_pkg::S_SCAN_CMP;
				end
			end
			rqd_pkg::S_SCAN_CMP: begin
				if (!st.match) begin
					cmd.scan_adv = 1'b1;
					state_d      = rqd_pkg::S_SCAN_RD;
				end else if (st.op == rqd_pkg::OP_FIND) begin
					cmd.finish  = 1'b1;
					cmd.fin_pos = 1'b1;
					state_d     = rqd_pkg::S_IDLE;
				end else begin
					state_d = rqd_pkg::S_SHIFT_RD;
				end
			end
			rqd_pkg::S_SHIFT_RD: begin
				if (st.shift_end) begin
					cmd.del_fin = 1'b1;
					cmd.finish  = 1'b1;
					state_d     = rqd_pkg::S_IDLE;
				end else begin
					cmd.shift_rd = 1'b1;
					state_d      = rqd_pkg::S_SHIFT_WR;
				end
			end
			rqd_pkg::S_SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
				state_d      = rqd_pkg::S_SHIFT_RD;
			end
			default: begin
				state_d = rqd_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ src/rqd_dpath.sv @@
// ----------------------------------------------------------------------------
// rqd_dpath
// Entry storage, head/tail/count registers, scan index and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "run_queue_deque_with_key_delete_macros.svh"

module rqd_dpath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire rqd_pkg::cmd_t               cmd,
	output rqd_pkg::stat_t                   st,
	input  wire logic [2:0]                  operation,
	input  wire logic [rqd_pkg::KEY_W-1:0]   key_in,
	input  wire logic [rqd_pkg::VAL_W-1:0]   value_in,
	output logic                             done,
	output logic [1:0]                       status,
	output logic [rqd_pkg::KEY_W-1:0]        key_out,
	output logic [rqd_pkg::VAL_W-1:0]        value_out,
	output logic [rqd_pkg::POS_W-1:0]        position,
	output logic [rqd_pkg::OCC_W-1:0]        occupancy
);

	logic [rqd_pkg::KEY_W-1:0] key_mem [rqd_pkg::DEPTH];
	logic [rqd_pkg::VAL_W-1:0] val_mem [rqd_pkg::DEPTH];

	rqd_pkg::ptr_t             head_q, tail_q, slot_q;
	rqd_pkg::cnt_t             count_q, idx_q;
	rqd_pkg::op_t              op_q;
	logic [rqd_pkg::KEY_W-1:0] key_q, key_rd_q;
	logic [rqd_pkg::VAL_W-1:0] val_q, val_rd_q;

	logic                      done_q;
	rqd_pkg::status_t          status_q;
	logic [rqd_pkg::KEY_W-1:0] key_out_q;
	logic [rqd_pkg::VAL_W-1:0] val_out_q;
	rqd_pkg::cnt_t             pos_q;

	logic                      rd_en, wr_en;
	rqd_pkg::ptr_t             rd_addr, wr_addr;
	logic [rqd_pkg::KEY_W-1:0] wr_key;
	logic [rqd_pkg::VAL_W-1:0] wr_val;
	rqd_pkg::cnt_t             idx_inc;
	logic [rqd_pkg::CNT_W:0]   ptr_sum;
	rqd_pkg::ptr_t             tail_exp;

	assign idx_inc = rqd_pkg::cnt_t'(idx_q + 1'b1);

	assign st.op        = op_q;
	assign st.full      = (count_q == rqd_pkg::CNT_W'(rqd_pkg::DEPTH));
	assign st.empty     = (count_q == '0);
	assign st.scan_end  = (idx_q == count_q);
	assign st.match     = (key_rd_q == key_q);
	assign st.shift_end = (idx_inc >= count_q);

	// memory port selection
	always_comb begin
		rd_en   = cmd.pop_rd | cmd.scan_rd | cmd.shift_rd;
		rd_addr = slot_q;
		if (cmd.pop_rd) begin
			rd_addr = head_q;
		end else if (cmd.shift_rd) begin
			rd_addr = rqd_pkg::slot_next(slot_q);
		end
		wr_en   = cmd.push_tail | cmd.push_head | cmd.shift_wr;
		wr_addr = slot_q;
		wr_key  = key_rd_q;
		wr_val  = val_rd_q;
		if (cmd.push_tail) begin
			wr_addr = tail_q;
			wr_key  = key_q;
			wr_val  = val_q;
		end else if (cmd.push_head) begin
			wr_addr = rqd_pkg::slot_prev(head_q);
			wr_key  = key_q;
			wr_val  = val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			val_mem[wr_addr] <= wr_val;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			key_rd_q <= key_mem[rd_addr];
			val_rd_q <= val_mem[rd_addr];
		end
	end

	// operand capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= key_in;
			val_q <= value_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= rqd_pkg::OP_PUSH_TAIL;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			slot_q  <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.load) begin
				op_q <= rqd_pkg::op_t'(operation);
			end
			if (cmd.push_tail) begin
				tail_q  <= rqd_pkg::slot_next(tail_q);
				count_q <= rqd_pkg::cnt_t'(count_q + 1'b1);
			end
			if (cmd.push_head) begin
				head_q  <= rqd_pkg::slot_prev(head_q);
				count_q <= rqd_pkg::cnt_t'(count_q + 1'b1);
			end
			if (cmd.pop_fin) begin
				head_q  <= rqd_pkg::slot_next(head_q);
				count_q <= rqd_pkg::cnt_t'(count_q - 1'b1);
			end
			if (cmd.del_fin) begin
				tail_q  <= rqd_pkg::slot_prev(tail_q);
				count_q <= rqd_pkg::cnt_t'(count_q - 1'b1);
			end
			if (cmd.clear) begin
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end
			if (cmd.scan_init) begin
				slot_q <= head_q;
				idx_q  <= '0;
			end
			if (cmd.scan_adv || cmd.shift_wr) begin
				slot_q <= rqd_pkg::slot_next(slot_q);
				idx_q  <= idx_inc;
			end
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q  <= cmd.status;
			key_out_q <= cmd.pop_fin ? key_rd_q : '0;
			val_out_q <= cmd.pop_fin ? val_rd_q : '0;
			pos_q     <= cmd.fin_pos ? idx_q : '0;
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign key_out   = key_out_q;
	assign value_out = val_out_q;
	assign position  = rqd_pkg::POS_W'(pos_q);
	assign occupancy = rqd_pkg::OCC_W'(count_q);

	// tail must always sit count entries past head
	assign ptr_sum  = (rqd_pkg::CNT_W + 1)'(head_q) + (rqd_pkg::CNT_W + 1)'(count_q);
	assign tail_exp = (ptr_sum >= (rqd_pkg::CNT_W + 1)'(rqd_pkg::DEPTH))
		? rqd_pkg::ptr_t'(ptr_sum - (rqd_pkg::CNT_W + 1)'(rqd_pkg::DEPTH))
		: rqd_pkg::ptr_t'(ptr_sum);

	`RQD_ASSERT_IMPLY(a_count_bound, clk, arst_n, 1'b1, count_q <= rqd_pkg::CNT_W'(rqd_pkg::DEPTH))
	`RQD_ASSERT_IMPLY(a_ptr_consistent, clk, arst_n, 1'b1, tail_q == tail_exp)
	`RQD_ASSERT_IMPLY(a_no_push_full, clk, arst_n, cmd.push_tail || cmd.push_head, !st.full)
	`RQD_ASSERT_NEXT(a_done_single, clk, arst_n, done_q, !done_q)

endmodule

`default_nettype wire

@@ src/run_queue_deque_with_key_delete.sv @@
// Push, clear and refused ops finish in the decode state; pop reads the head entry, then
// finishes in its own state; find/delete scan the entries from head, a read and a compare per
// entry, and a delete hit then moves each later entry down one slot before the tail steps back.
// One operation at a time; busy is high until finish and the next start is taken in the
// done cycle, so an operation holds the block until its done strobe.
// Asynchronous active-low reset empties the queue; done lasts one cycle and cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module run_queue_deque_with_key_delete (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [2:0]                operation,
	input  wire logic [rqd_pkg::KEY_W-1:0] key_in,
	input  wire logic [rqd_pkg::VAL_W-1:0] value_in,
	output logic                           done,
	output logic [1:0]                     status,
	output logic [rqd_pkg::KEY_W-1:0]      key_out,
	output logic [rqd_pkg::VAL_W-1:0]      value_out,
	output logic [rqd_pkg::POS_W-1:0]      position,
	output logic [rqd_pkg::OCC_W-1:0]      occupancy
);

	rqd_pkg::cmd_t  cmd;
	rqd_pkg::stat_t st;

	rqd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	rqd_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.operation (operation),
		.key_in    (key_in),
		.value_in  (value_in),
		.done      (done),
		.status    (status),
		.key_out   (key_out),
		.value_out (value_out),
		.position  (position),
		.occupancy (occupancy)
	);

endmodule

`default_nettype wire
